// ===== sv/mhvc_pkg.sv =====
// shared constants, codes and the hash mixing step of the vertex colouring block
// no dependencies
`default_nettype none

package mhvc_pkg;

    localparam int HC_W    = 5;
    localparam int ID_W    = 32;
    localparam int SEED_W  = 32;
    localparam int COLOR_W = 31;

    // request codes
    localparam logic [1:0] REQ_BEGIN    = 2'd0;
    localparam logic [1:0] REQ_NEIGHBOR = 2'd1;
    localparam logic [1:0] REQ_END      = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_HASH_COUNT = 2'd0;
    localparam logic [1:0] CFG_ROUND_SEED = 2'd1;
    localparam logic [1:0] CFG_BASE_COLOR = 2'd2;

    localparam logic [HC_W-1:0]    HASH_COUNT_RST = 5'd1;
    localparam logic [SEED_W-1:0]  ROUND_SEED_RST = 32'd1012;
    localparam logic [COLOR_W-1:0] BASE_COLOR_RST = 31'd0;

    localparam logic [SEED_W-1:0] SEED_STEP = 32'd1043;

    localparam int MIX_STEPS = 6;
    localparam logic [31:0] MIX_C0 = 32'h7ed55d16;
    localparam logic [31:0] MIX_C1 = 32'hc761c23c;
    localparam logic [31:0] MIX_C2 = 32'h165667b1;
    localparam logic [31:0] MIX_C3 = 32'hd3a2646c;
    localparam logic [31:0] MIX_C4 = 32'hfd7046c5;
    localparam logic [31:0] MIX_C5 = 32'hb55a4f09;

    // one step of the integer mix, k selects the step
    function automatic logic [31:0] mix_step(input logic [2:0] k, input logic [31:0] a);
        logic [31:0] r;
        case (k)
            3'd0:    r = (a + MIX_C0) + (a << 12);
            3'd1:    r = (a ^ MIX_C1) + (a >> 19);
            3'd2:    r = (a + MIX_C2) + (a << 5);
            3'd3:    r = (a ^ MIX_C3) + (a << 9);
            3'd4:    r = (a + MIX_C4) + (a << 3);
            3'd5:    r = (a ^ MIX_C5) + (a >> 16);
            default: r = a;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== sv/mhvc_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module mhvc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                      wdata,
    input  wire logic                                  re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== sv/mhvc_hash.sv =====
// six stage pipelined integer hash, one evaluation per cycle, tag carried along
// depends on mhvc_pkg
`default_nettype none

module mhvc_hash #(
    parameter int TAG_W = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire logic [31:0]      in_key,
    input  wire logic [31:0]      in_seed,
    input  wire logic [TAG_W-1:0] in_tag,
    output logic                  ahead_valid,
    output logic      [TAG_W-1:0] ahead_tag,
    output logic                  out_valid,
    output logic      [TAG_W-1:0] out_tag,
    output logic      [31:0]      out_hash
);

    localparam int N = mhvc_pkg::MIX_STEPS;

    logic             valid_reg [N];
    logic [TAG_W-1:0] tag_reg   [N];
    logic [31:0]      data_reg  [N];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < N; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            valid_reg[0] <= in_valid;
            for (int i = 1; i < N; i++)
            begin
                valid_reg[i] <= valid_reg[i-1];
            end
        end
    end

    // one mixing step per stage, seed folded in ahead of the first
    always_ff @(posedge clk)
    begin
        data_reg[0] <= mhvc_pkg::mix_step(3'd0, in_key ^ in_seed);
        tag_reg[0]  <= in_tag;
        for (int i = 1; i < N; i++)
        begin
            data_reg[i] <= mhvc_pkg::mix_step(3'(i), data_reg[i-1]);
            tag_reg[i]  <= tag_reg[i-1];
        end
    end

    assign ahead_valid = valid_reg[N-2];
    assign ahead_tag   = tag_reg[N-2];
    assign out_valid   = valid_reg[N-1];
    assign out_tag     = tag_reg[N-1];
    assign out_hash    = data_reg[N-1];

endmodule

`default_nettype wire

// ===== sv/mhvc_mod.sv =====
// bit serial restoring remainder of a 32-bit value by a narrow divisor
// no dependencies
`default_nettype none

module mhvc_mod #(
    parameter int DIV_W = 6
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [31:0]      dividend,
    input  wire logic [DIV_W-1:0] divisor,
    output logic                  done,
    output logic      [DIV_W-1:0] remainder
);

    logic             busy_reg;
    logic             done_reg;
    logic [4:0]       cnt_reg;
    logic [31:0]      quo_reg;
    logic [DIV_W-1:0] div_reg;
    logic [DIV_W-1:0] rem_reg;
    logic [DIV_W:0]   trial;
    logic [DIV_W-1:0] rem_next;

    always_comb
    begin
        trial = {rem_reg, quo_reg[31]};
        if (trial >= {1'b0, div_reg})
        begin
            rem_next = DIV_W'(trial - {1'b0, div_reg});
        end
        else
        begin
            rem_next = trial[DIV_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            div_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[30:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

// ===== sv/multi_hash_min_max_vertex_color.sv =====
// top level of the min-max multi-hash vertex colouring block
// depends on mhvc_pkg, mhvc_ram, mhvc_hash, mhvc_mod
//
// usage
//   input channel (in_valid / in_stall): a begin transaction opens a vertex, neighbour
//   transactions follow, an end transaction closes it and yields one result transaction
//   output channel (out_valid / out_stall): vertex_id, colored, color
//   config channel (cfg_valid / cfg_ready): always ready, write only while idle
// sequence of each accepted input transaction, H = MAX_HASHES, h = hash count
//   begin: all H hashes of the vertex pass the hash pipeline into the ram
//   counted neighbour: h hashes, one hash per cycle against the ram word
//   skipped neighbour (done, self loop, blocked) or unknown request: stays idle
//   end: the free slots of the h hashes are counted, the serial remainder picks one and
//   the slot scan finds it (both skipped when blocked or none free), then the output register
//   takes the result; the six stage hash pipeline and the 32 step remainder unit pace these
// reset clears the configuration to its defaults and all control state; the hash ram
//   holds nothing valid until the first begin transaction
// a stalled result stays in the output register while the next items are taken; only
//   a following end transaction waits for that register to drain
`default_nettype none

module multi_hash_min_max_vertex_color #(
    parameter int MAX_HASHES = 16
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // input items
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [1:0]                     req_type,
    input  wire logic [mhvc_pkg::ID_W-1:0]      item_id,
    input  wire logic                           neighbor_done,
    // results
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic      [mhvc_pkg::ID_W-1:0]      vertex_id,
    output logic                                colored,
    output logic      [mhvc_pkg::COLOR_W-1:0]   color,
    // configuration writes
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [1:0]                     cfg_index,
    input  wire logic [31:0]                    cfg_data
);

    localparam int IDX_W  = (MAX_HASHES > 1) ? $clog2(MAX_HASHES) : 1;
    localparam int CNT_W  = $clog2(MAX_HASHES + 1);
    localparam int FREE_W = $clog2(2 * MAX_HASHES + 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_HASH  = 3'd1;
    localparam logic [2:0] ST_NFIN  = 3'd2;
    localparam logic [2:0] ST_COUNT = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;
    localparam logic [2:0] ST_SCAN  = 3'd5;
    localparam logic [2:0] ST_EMIT  = 3'd6;

    // configuration
    logic [mhvc_pkg::HC_W-1:0]    hash_count_reg;
    logic [mhvc_pkg::SEED_W-1:0]  round_seed_reg;
    logic [mhvc_pkg::COLOR_W-1:0] base_color_reg;

    // vertex state
    logic [mhvc_pkg::ID_W-1:0] cur_vertex_reg;
    logic [MAX_HASHES-1:0]     min_taken_reg;
    logic [MAX_HASHES-1:0]     max_taken_reg;
    logic                      blocked_reg;

    // sequencer
    logic [2:0]                  state_reg;
    logic                        is_begin_reg;
    logic [CNT_W-1:0]            hc_reg;
    logic [CNT_W-1:0]            t_reg;
    logic [CNT_W-1:0]            n_issue_reg;
    logic [CNT_W-1:0]            rcnt_reg;
    logic [mhvc_pkg::ID_W-1:0]   key_reg;
    logic [mhvc_pkg::SEED_W-1:0] seed_reg;
    logic [FREE_W-1:0]           free_reg;
    logic [FREE_W-1:0]           pick_reg;
    logic [FREE_W-1:0]           pos_reg;
    logic                        res_colored_reg;
    logic [mhvc_pkg::COLOR_W-1:0] res_color_reg;

    // output register
    logic                          out_valid_reg;
    logic [mhvc_pkg::ID_W-1:0]     vertex_id_reg;
    logic                          colored_reg;
    logic [mhvc_pkg::COLOR_W-1:0]  color_reg;

    logic             in_take;
    logic             out_free;
    logic [CNT_W-1:0] eff_count;
    logic [IDX_W-1:0] t_idx;
    logic             hash_issue;
    logic             min_free;
    logic             max_free;
    logic             all_taken;
    logic [mhvc_pkg::COLOR_W-1:0] col_min;
    logic [mhvc_pkg::COLOR_W-1:0] col_max;
    logic [FREE_W-1:0] pos_after_min;

    // hash pipeline and ram
    logic             h_ahead_valid;
    logic [IDX_W-1:0] h_ahead_tag;
    logic             h_out_valid;
    logic [IDX_W-1:0] h_out_tag;
    logic [31:0]      h_out_hash;
    logic [31:0]      ram_rdata;
    logic             ram_we;
    logic             ram_re;

    // remainder unit
    logic              mod_start;
    logic              mod_done;
    logic [FREE_W-1:0] mod_rem;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_take   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign cfg_ready = 1'b1;

    // out-of-range hash count clamps to 1 .. MAX_HASHES
    always_comb
    begin
        if (hash_count_reg == '0)
        begin
            eff_count = CNT_W'(1);
        end
        else if (hash_count_reg > mhvc_pkg::HC_W'(MAX_HASHES))
        begin
            eff_count = CNT_W'(MAX_HASHES);
        end
        else
        begin
            eff_count = CNT_W'(hash_count_reg);
        end
    end

    assign t_idx      = t_reg[IDX_W-1:0];
    assign hash_issue = (state_reg == ST_HASH) && (t_reg < n_issue_reg);
    assign min_free   = !min_taken_reg[t_idx];
    assign max_free   = !max_taken_reg[t_idx];

    // every slot below the hash count taken
    always_comb
    begin
        all_taken = 1'b1;
        for (int i = 0; i < MAX_HASHES; i++)
        begin
            if ((CNT_W'(i) < hc_reg) && !(min_taken_reg[i] && max_taken_reg[i]))
            begin
                all_taken = 1'b0;
            end
        end
    end

    // colour numbers of the scanned hash, wrapping in 31 bits
    assign col_min = base_color_reg + mhvc_pkg::COLOR_W'({t_reg, 1'b0});
    assign col_max = base_color_reg + mhvc_pkg::COLOR_W'({t_reg, 1'b1});
    assign pos_after_min = pos_reg + FREE_W'(min_free);

    assign ram_we = h_out_valid && is_begin_reg;
    assign ram_re = h_ahead_valid && !is_begin_reg;

    assign mod_start = (state_reg == ST_COUNT) && !(t_reg < hc_reg)
                       && !blocked_reg && (free_reg != '0);

    mhvc_hash #(
        .TAG_W(IDX_W)
    ) u_hash (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (hash_issue),
        .in_key     (key_reg),
        .in_seed    (seed_reg),
        .in_tag     (t_idx),
        .ahead_valid(h_ahead_valid),
        .ahead_tag  (h_ahead_tag),
        .out_valid  (h_out_valid),
        .out_tag    (h_out_tag),
        .out_hash   (h_out_hash)
    );

    mhvc_ram #(
        .WIDTH(32),
        .DEPTH(MAX_HASHES)
    ) u_vertex_hashes (
        .clk  (clk),
        .we   (ram_we),
        .waddr(h_out_tag),
        .wdata(h_out_hash),
        .re   (ram_re),
        .raddr(h_ahead_tag),
        .rdata(ram_rdata)
    );

    mhvc_mod #(
        .DIV_W(FREE_W)
    ) u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (cur_vertex_reg),
        .divisor  (free_reg),
        .done     (mod_done),
        .remainder(mod_rem)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_count_reg <= mhvc_pkg::HASH_COUNT_RST;
            round_seed_reg <= mhvc_pkg::ROUND_SEED_RST;
            base_color_reg <= mhvc_pkg::BASE_COLOR_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                mhvc_pkg::CFG_HASH_COUNT: hash_count_reg <= cfg_data[mhvc_pkg::HC_W-1:0];
                mhvc_pkg::CFG_ROUND_SEED: round_seed_reg <= cfg_data;
                mhvc_pkg::CFG_BASE_COLOR: base_color_reg <= cfg_data[mhvc_pkg::COLOR_W-1:0];
                default:                  ;
            endcase
        end
    end

    // sequencer and vertex state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            is_begin_reg    <= 1'b0;
            hc_reg          <= CNT_W'(1);
            t_reg           <= '0;
            n_issue_reg     <= '0;
            rcnt_reg        <= '0;
            key_reg         <= '0;
            seed_reg        <= '0;
            cur_vertex_reg  <= '0;
            min_taken_reg   <= '0;
            max_taken_reg   <= '0;
            blocked_reg     <= 1'b0;
            free_reg        <= '0;
            pick_reg        <= '0;
            pos_reg         <= '0;
            res_colored_reg <= 1'b0;
            res_color_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_take)
                    begin
                        hc_reg   <= eff_count;
                        t_reg    <= '0;
                        rcnt_reg <= '0;
                        key_reg  <= item_id;
                        // seed of hash 0, stepped on each issue
                        seed_reg <= round_seed_reg;
                        case (req_type)
                            mhvc_pkg::REQ_BEGIN:
                            begin
                                cur_vertex_reg <= item_id;
                                min_taken_reg  <= '0;
                                max_taken_reg  <= '0;
                                blocked_reg    <= 1'b0;
                                is_begin_reg   <= 1'b1;
                                n_issue_reg    <= CNT_W'(MAX_HASHES);
                                state_reg      <= ST_HASH;
                            end
                            mhvc_pkg::REQ_NEIGHBOR:
                            begin
                                // done, self loop or blocked vertex: nothing to do
                                if (!blocked_reg && !neighbor_done
                                    && (item_id != cur_vertex_reg))
                                begin
                                    is_begin_reg <= 1'b0;
                                    n_issue_reg  <= eff_count;
                                    state_reg    <= ST_HASH;
                                end
                            end
                            mhvc_pkg::REQ_END:
                            begin
                                free_reg  <= '0;
                                state_reg <= ST_COUNT;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end

                ST_HASH:
                begin
                    if (hash_issue)
                    begin
                        t_reg    <= t_reg + CNT_W'(1);
                        seed_reg <= seed_reg + mhvc_pkg::SEED_STEP;
                    end
                    if (h_out_valid)
                    begin
                        rcnt_reg <= rcnt_reg + CNT_W'(1);
                        if (!is_begin_reg)
                        begin
                            if (ram_rdata <= h_out_hash)
                            begin
                                max_taken_reg[h_out_tag] <= 1'b1;
                            end
                            if (ram_rdata >= h_out_hash)
                            begin
                                min_taken_reg[h_out_tag] <= 1'b1;
                            end
                        end
                        if (rcnt_reg == n_issue_reg - CNT_W'(1))
                        begin
                            state_reg <= is_begin_reg ? ST_IDLE : ST_NFIN;
                        end
                    end
                end

                ST_NFIN:
                begin
                    blocked_reg <= all_taken;
                    state_reg   <= ST_IDLE;
                end

                ST_COUNT:
                begin
                    if (t_reg < hc_reg)
                    begin
                        free_reg <= free_reg + FREE_W'(min_free) + FREE_W'(max_free);
                        t_reg    <= t_reg + CNT_W'(1);
                    end
                    else if (blocked_reg || (free_reg == '0))
                    begin
                        res_colored_reg <= 1'b0;
                        res_color_reg   <= '0;
                        state_reg       <= ST_EMIT;
                    end
                    else
                    begin
                        state_reg <= ST_DIV;
                    end
                end

                ST_DIV:
                begin
                    if (mod_done)
                    begin
                        pick_reg  <= mod_rem;
                        pos_reg   <= '0;
                        t_reg     <= '0;
                        state_reg <= ST_SCAN;
                    end
                end

                ST_SCAN:
                begin
                    // min slot before max slot of the same hash
                    if (min_free && (pos_reg == pick_reg))
                    begin
                        res_colored_reg <= 1'b1;
                        res_color_reg   <= col_min;
                        state_reg       <= ST_EMIT;
                    end
                    else if (max_free && (pos_after_min == pick_reg))
                    begin
                        res_colored_reg <= 1'b1;
                        res_color_reg   <= col_max;
                        state_reg       <= ST_EMIT;
                    end
                    else
                    begin
                        pos_reg <= pos_after_min + FREE_W'(max_free);
                        t_reg   <= t_reg + CNT_W'(1);
                    end
                end

                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((state_reg == ST_EMIT) && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_EMIT) && out_free)
        begin
            vertex_id_reg <= cur_vertex_reg;
            colored_reg   <= res_colored_reg;
            color_reg     <= res_color_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign vertex_id = vertex_id_reg;
    assign colored   = colored_reg;
    assign color     = color_reg;

endmodule

`default_nettype wire
